// ===== src/pdisp_pkg.sv =====
// Shared constants, codes and control types of the periodic task dispatcher.
`default_nettype none
package pdisp_pkg;
   localparam int MaxTasks = 8;
   localparam int IdxW     = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
   localparam int CntW     = $clog2(MaxTasks + 1);
   localparam int TimeW    = 32;
   localparam int KindW    = 2;
   localparam int EvW      = 2;
   localparam int WantW    = 3;
   localparam int SlotW    = 3;
   localparam int InUseW   = 4;
   localparam int ReqDataW = 72;
   localparam int RspDataW = 8;

   localparam logic [KindW-1:0] KindRegister = 2'd0;
   localparam logic [KindW-1:0] KindTick     = 2'd1;
   localparam logic [KindW-1:0] KindFire     = 2'd2;

   localparam logic [EvW-1:0] EvRegistered = 2'd0;
   localparam logic [EvW-1:0] EvRejected   = 2'd1;
   localparam logic [EvW-1:0] EvFired      = 2'd2;
   localparam logic [EvW-1:0] EvNone       = 2'd3;

   typedef struct packed {
      logic load;
      logic single;
      logic scan_step;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
      logic due_empty;
      logic due_final;
   } dp_status_type;
endpackage
`default_nettype wire

// ===== src/pdisp_ctrl.sv =====
// Controller state machine that sequences accept, table scan and result beats.
`default_nettype none
module pdisp_ctrl
   import pdisp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   input  wire logic [KindW-1:0] req_kind,
   output logic                  req_tready,
   output dp_cmd_type            cmd,
   input  dp_status_type         status
);
   typedef enum logic [1:0] {ST_IDLE, ST_SINGLE, ST_SCAN, ST_EMIT} state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && ready_ff) begin
               cmd.load = 1'b1;
               state_in = (req_kind == KindTick) ? ST_SCAN : ST_SINGLE;
            end
         end
         ST_SINGLE: begin
            if (status.out_free) begin
               cmd.single = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_EMIT;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.due_empty || status.due_final) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == ST_IDLE);
      end
   end

   assign req_tready = ready_ff;
endmodule
`default_nettype wire

// ===== src/pdisp_dp.sv =====
// Datapath with the task tables, the scan counter, the due mask and the result register.
`default_nettype none
module pdisp_dp
   import pdisp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  dp_cmd_type               cmd,
   output dp_status_type            status,
   input  wire logic [KindW-1:0]    in_kind,
   input  wire logic [TimeW-1:0]    in_now,
   input  wire logic [TimeW-1:0]    in_interval,
   input  wire logic [WantW-1:0]    in_want,
   input  wire logic                rsp_tready,
   output logic                     rsp_tvalid,
   output logic [EvW-1:0]           rsp_event,
   output logic [SlotW-1:0]         rsp_slot,
   output logic [InUseW-1:0]        rsp_in_use,
   output logic                     rsp_last
);
   logic [KindW-1:0]  kind_ff;
   logic [TimeW-1:0]  now_ff;
   logic [TimeW-1:0]  interval_ff;
   logic [WantW-1:0]  want_ff;
   logic [CntW-1:0]   total_ff;
   logic [CntW-1:0]   idx_ff;
   logic [MaxTasks-1:0] due_ff;
   logic [TimeW-1:0]  period_mem [MaxTasks];
   logic [TimeW-1:0]  last_mem   [MaxTasks];

   logic              valid_ff;
   logic [EvW-1:0]    event_ff;
   logic [SlotW-1:0]  slot_ff;
   logic [InUseW-1:0] in_use_ff;
   logic              last_ff;

   logic [IdxW-1:0]   scan_idx;
   logic [IdxW-1:0]   fire_idx;
   logic [IdxW-1:0]   rd_idx;
   logic [TimeW-1:0]  elapsed;
   logic              is_due;
   logic              table_full;
   logic              fire_ok;
   logic [IdxW-1:0]   low_idx;
   logic [MaxTasks-1:0] due_rest;
   logic [EvW-1:0]    sgl_event;
   logic [SlotW-1:0]  sgl_slot;
   logic [CntW-1:0]   sgl_total;

   assign scan_idx   = idx_ff[IdxW-1:0];
   assign fire_idx   = IdxW'(want_ff);
   assign rd_idx     = (kind_ff == KindTick) ? scan_idx : fire_idx;
   assign elapsed    = now_ff - last_mem[rd_idx];
   assign is_due     = (elapsed >= period_mem[rd_idx]);
   assign table_full = (total_ff == CntW'(MaxTasks));
   assign fire_ok    = (32'(want_ff) < 32'(total_ff));
   assign due_rest   = due_ff & (due_ff - MaxTasks'(1));

   always_comb begin
      low_idx = '0;
      for (int i = MaxTasks - 1; i >= 0; i--) begin
         if (due_ff[i]) begin
            low_idx = IdxW'(i);
         end
      end
   end

   always_comb begin
      sgl_event = EvNone;
      sgl_slot  = '0;
      sgl_total = total_ff;
      case (kind_ff)
         KindRegister: begin
            if (table_full) begin
               sgl_event = EvRejected;
            end else begin
               sgl_event = EvRegistered;
               sgl_slot  = SlotW'(total_ff);
               sgl_total = total_ff + CntW'(1);
            end
         end
         KindFire: begin
            if (fire_ok) begin
               sgl_event = EvFired;
               sgl_slot  = SlotW'(want_ff);
            end
         end
         default: begin
            sgl_event = EvNone;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff     <= in_kind;
         now_ff      <= in_now;
         interval_ff <= in_interval;
         want_ff     <= in_want;
      end
      if (cmd.single && kind_ff == KindRegister && !table_full) begin
         period_mem[total_ff[IdxW-1:0]] <= interval_ff;
         last_mem[total_ff[IdxW-1:0]]   <= now_ff;
      end
      if (cmd.single && kind_ff == KindFire && fire_ok) begin
         last_mem[fire_idx] <= now_ff;
      end
      if (cmd.scan_step && is_due) begin
         last_mem[scan_idx] <= now_ff;
      end
      if (cmd.single) begin
         event_ff  <= sgl_event;
         slot_ff   <= sgl_slot;
         in_use_ff <= InUseW'(sgl_total);
         last_ff   <= 1'b1;
      end else if (cmd.emit) begin
         event_ff  <= (due_ff == '0) ? EvNone : EvFired;
         slot_ff   <= (due_ff == '0) ? '0 : SlotW'(low_idx);
         in_use_ff <= InUseW'(total_ff);
         last_ff   <= (due_rest == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         idx_ff   <= '0;
         due_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (cmd.single && kind_ff == KindRegister) begin
            total_ff <= sgl_total;
         end
         if (cmd.load) begin
            idx_ff <= '0;
            due_ff <= '0;
         end else if (cmd.scan_step) begin
            idx_ff <= idx_ff + CntW'(1);
            if (is_due) begin
               due_ff[scan_idx] <= 1'b1;
            end
         end else if (cmd.emit) begin
            due_ff <= due_rest;
         end
         if (cmd.single || cmd.emit) begin
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign status.scan_done = (idx_ff == total_ff);
   assign status.out_free  = !valid_ff || rsp_tready;
   assign status.due_empty = (due_ff == '0);
   assign status.due_final = (due_rest == '0);

   assign rsp_tvalid = valid_ff;
   assign rsp_event  = event_ff;
   assign rsp_slot   = slot_ff;
   assign rsp_in_use = in_use_ff;
   assign rsp_last   = last_ff;
endmodule
`default_nettype wire

// ===== src/periodic_task_dispatcher_core.sv =====
// Register and fire-now items: the item is registered at accept, then its result beat once the
// output is free; the next item is accepted after that beat is registered. Tick items: the scan
// steps through each registered task in turn, then one result beat per cycle for each fired task
// (or one idle beat), all stalls excepted. The table scan uses a single subtract and compare.
// Synchronous reset empties the task table; table entries are not cleared.
`default_nettype none
module periodic_task_dispatcher_core
   import pdisp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [ReqDataW-1:0] req_tdata,  // now_ms, period_ms, task_index, zero pad
   input  wire logic [KindW-1:0]    req_tuser,  // kind
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [RspDataW-1:0]      rsp_tdata,  // slot, tasks_in_use, zero pad
   output logic [EvW-1:0]           rsp_tuser,  // event_res
   output logic                     rsp_tlast
);
   dp_cmd_type        cmd;
   dp_status_type     status;
   logic [SlotW-1:0]  slot;
   logic [InUseW-1:0] in_use;

   pdisp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   pdisp_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .in_kind     (req_tuser),
      .in_now      (req_tdata[31:0]),
      .in_interval (req_tdata[63:32]),
      .in_want     (req_tdata[66:64]),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_event   (rsp_tuser),
      .rsp_slot    (slot),
      .rsp_in_use  (in_use),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, in_use, slot};
endmodule
`default_nettype wire

// ===== src/pdisp_checker.sv =====
// Port-level assertions for the dispatcher and their binding to the top level.
`default_nettype none
module pdisp_checker
   import pdisp_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_tvalid,
   input wire logic                req_tready,
   input wire logic                rsp_tvalid,
   input wire logic                rsp_tready,
   input wire logic [RspDataW-1:0] rsp_tdata,
   input wire logic [EvW-1:0]      rsp_tuser,
   input wire logic                rsp_tlast
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Result beat changed while stalled.");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("Request accepted while an item is still in work.");

   a_reject_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == EvRejected |->
         rsp_tdata[6:3] == InUseW'(MaxTasks) && rsp_tlast)
      else $error("Register rejected while the table had room.");

   a_register_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == EvRegistered |->
         rsp_tdata[2:0] == SlotW'(rsp_tdata[6:3] - InUseW'(1)) && rsp_tlast)
      else $error("Registered slot does not match the task count.");
endmodule

bind periodic_task_dispatcher_core pdisp_checker u_pdisp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
